/* hw/rtl/khtt_pkg.sv */
// Shared types and codes for the key hold time table.
package khtt_pkg;

  localparam int MODE_W     = 2;
  localparam int KEY_CODE_W = 8;
  localparam int NOW_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int HOLD_W     = 32;
  localparam int COUNT_W    = 5;

  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

endpackage

/* hw/rtl/key_hold_time_table_core.sv */
// Top level of the key hold time table: held keys with their press times.
//
// Each beat on the input is a press, a release or a presence query for one key. Keys and
// press times live in one slot memory with a single read port; per-slot valid bits sit in
// flops and are cleared by reset, so no clearing pass is needed. An accepted item scans
// the slot memory one entry per cycle, stopping early on a hit, then updates the table
// and loads the result register. The input stalls while an item is scanned and executed;
// a new item is taken only in the idle state, once the last one has loaded its result.
// A new item is taken while a finished result still waits at the output. held_count
// reports the number of keys held after the item.
module key_hold_time_table_core
  import khtt_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [KEY_CODE_W-1:0] in_key_code,
  input  logic [NOW_W-1:0]      in_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [HOLD_W-1:0]     out_hold_time,
  output logic [COUNT_W-1:0]    out_held_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = KEY_BITS + TIME_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]    mode_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] now_r;

  logic [AW-1:0] idx_r;
  logic [AW-1:0] cidx_r;
  logic          rd_vld_r;
  logic          issued_all_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [TIME_BITS-1:0] hit_time_r;
  logic          free_found_r;
  logic [AW-1:0] free_idx_r;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HOLD_W-1:0]   out_hold_r;
  logic [COUNT_W-1:0]  out_count_r;

  // control strobes
  logic accept;
  logic issue;
  logic exec_fire;

  // scan compare
  logic [DW-1:0]        rdata;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_time;
  logic                 cmp_live;
  logic                 cmp_hit;
  logic                 cmp_free;
  logic                 scan_done;

  // execute
  logic                     ram_we;
  logic [STATUS_W-1:0]      status_c;
  logic [TIME_BITS-1:0]     hold_c;
  logic [TIME_BITS-1:0]     diff;
  logic [TIME_BITS+HOLD_W-1:0] hold_ext;
  logic [CW+COUNT_W-1:0]    cnt_ext;

  logic [KEY_BITS+KEY_CODE_W-1:0] key_ext;
  logic [TIME_BITS+NOW_W-1:0]     now_ext;
  logic [KEY_BITS-1:0]            key_in;
  logic [TIME_BITS-1:0]           now_in;

  assign key_ext = {{KEY_BITS{1'b0}}, in_key_code};
  assign key_in  = key_ext[KEY_BITS-1:0];
  assign now_ext = {{TIME_BITS{1'b0}}, in_now};
  assign now_in  = now_ext[TIME_BITS-1:0];

  khtt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata ({key_r, now_r}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_key  = rdata[DW-1:TIME_BITS];
  assign rd_time = rdata[TIME_BITS-1:0];

  // read data belongs to cidx_r, issued in the previous cycle
  assign cmp_live  = (state_r == ST_SCAN) && rd_vld_r;
  assign cmp_hit   = cmp_live && valid_r[cidx_r] && (rd_key == key_r);
  assign cmp_free  = cmp_live && !valid_r[cidx_r];
  assign scan_done = cmp_live && (cmp_hit || (cidx_r == LAST_IDX));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    issue     = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCAN: begin
        issue = !issued_all_r;
      end
      ST_EXEC: begin
        exec_fire = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  assign diff = now_r - hit_time_r;

  // table update and result
  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    hold_c    = '0;
    status_c  = STAT_NOT_FOUND;
    case (mode_r)
      MODE_PRESS: begin
        if (hit_r) begin
          status_c = STAT_DUPLICATE;
        end else if (!free_found_r) begin
          status_c = STAT_FULL;
        end else begin
          status_c              = STAT_INSERTED;
          ram_we                = exec_fire;
          valid_nxt[free_idx_r] = 1'b1;
          cnt_nxt               = cnt_r + CW'(1);
        end
      end
      MODE_RELEASE: begin
        if (hit_r) begin
          status_c             = STAT_RELEASED;
          hold_c               = diff;
          valid_nxt[hit_idx_r] = 1'b0;
          cnt_nxt              = cnt_r - CW'(1);
        end
      end
      MODE_QUERY: begin
        status_c = hit_r ? STAT_PRESENT : STAT_NOT_FOUND;
      end
      default: begin
        status_c = hit_r ? STAT_PRESENT : STAT_NOT_FOUND;
      end
    endcase
  end

  assign hold_ext = {{HOLD_W{1'b0}}, hold_c};
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      issued_all_r <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        rd_vld_r     <= 1'b0;
        issued_all_r <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        rd_vld_r <= issue;
        if (issue && (idx_r == LAST_IDX)) begin
          issued_all_r <= 1'b1;
        end
        if (cmp_hit) begin
          hit_r <= 1'b1;
        end
        if (cmp_free) begin
          free_found_r <= 1'b1;
        end
      end
      if (exec_fire) begin
        valid_r     <= valid_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= key_in;
      now_r  <= now_in;
      idx_r  <= '0;
    end else if (issue) begin
      idx_r <= idx_r + AW'(1);
    end
    cidx_r <= idx_r;
    if (cmp_hit) begin
      hit_idx_r  <= cidx_r;
      hit_time_r <= rd_time;
    end
    // keep the lowest free slot
    if (cmp_free && !free_found_r) begin
      free_idx_r <= cidx_r;
    end
    if (exec_fire) begin
      out_status_r <= status_c;
      out_hold_r   <= hold_ext[HOLD_W-1:0];
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hold_time  = out_hold_r;
  assign out_held_count = out_count_r;

endmodule

/* hw/rtl/khtt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module khtt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/khtt_checker.sv */
// Port-level checks for the key hold time table, bound to the top level.
module khtt_checker
  import khtt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [HOLD_W-1:0]   out_hold_time,
  input logic [COUNT_W-1:0]  out_held_count
);

  // only a release measures a hold time
  a_hold_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_RELEASED) |-> (out_hold_time == '0))
    else $error("hold time nonzero on a non-release result");

  // a dropped press means every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |->
      ((ENTRIES > 31) || (int'(out_held_count) == ENTRIES)))
    else $error("full status with free slots");

  // an insert leaves at least one key held
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_INSERTED) |-> (out_held_count != '0))
    else $error("insert reported with empty table");

  // one item at a time: an accepted beat is followed by a busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_hold_time) && $stable(out_held_count))
    else $error("stalled result beat changed");

endmodule

bind key_hold_time_table_core khtt_checker #(.ENTRIES(ENTRIES)) u_khtt_checker (.*);
